@@ design/calu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// calu_pkg
// shared types and codes for the 8-bit alu with z/n/h/c flags
// ----------------------------------------------------------------------------
package calu_pkg;

	localparam int unsigned DataWidth = 8;
	localparam int unsigned OpWidth   = 4;

	typedef logic [DataWidth-1:0] data_t;

	typedef enum logic [OpWidth-1:0] {
		OP_ADD  = 4'd0,
		OP_ADC  = 4'd1,
		OP_SUB  = 4'd2,
		OP_SBC  = 4'd3,
		OP_RLC  = 4'd4,
		OP_RRC  = 4'd5,
		OP_SLA  = 4'd6,
		OP_SRA  = 4'd7,
		OP_SRL  = 4'd8,
		OP_SWAP = 4'd9,
		OP_CCF  = 4'd10,
		OP_INC  = 4'd11
	} op_t;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	localparam flags_t FlagsReset = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};

endpackage

`default_nettype wire

@@ design/calu_exec.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// calu_exec
// combinational execute unit: result byte and next flags for one word
// ----------------------------------------------------------------------------
module calu_exec import calu_pkg::*; (
	input  wire logic [OpWidth-1:0] op,
	input  wire data_t              operand_a,
	input  wire data_t              operand_b,
	input  wire flags_t             flags_cur,
	output data_t                   result,
	output flags_t                  flags_nxt
);

	logic       ci;
	logic [8:0] sum9;
	logic [4:0] sum5;
	logic [8:0] dif9;
	logic [4:0] dif5;
	data_t      res;
	flags_t     fl;
	logic       known;

	// carry-in only for the with-carry forms
	assign ci = flags_cur.c & ((op == OP_ADC) | (op == OP_SBC));

	assign sum9 = {1'b0, operand_a} + {1'b0, operand_b} + {8'd0, ci};
	assign sum5 = {1'b0, operand_a[3:0]} + {1'b0, operand_b[3:0]} + {4'd0, ci};
	assign dif9 = {1'b0, operand_a} - {1'b0, operand_b} - {8'd0, ci};
	assign dif5 = {1'b0, operand_a[3:0]} - {1'b0, operand_b[3:0]} - {4'd0, ci};

	always_comb begin
		res   = operand_a;
		fl    = FlagsReset;
		known = 1'b1;
		unique case (op_t'(op))
			OP_ADD, OP_ADC: begin
				res  = sum9[7:0];
				fl.h = sum5[4];
				fl.c = sum9[8];
			end
			OP_SUB, OP_SBC: begin
				res  = dif9[7:0];
				fl.n = 1'b1;
				fl.h = dif5[4];
				fl.c = dif9[8];
			end
			OP_RLC: begin
				res  = {operand_a[6:0], operand_a[7]};
				fl.c = operand_a[7];
			end
			OP_RRC: begin
				res  = {operand_a[0], operand_a[7:1]};
				fl.c = operand_a[0];
			end
			OP_SLA: begin
				res  = {operand_a[6:0], 1'b0};
				fl.c = operand_a[7];
			end
			OP_SRA: begin
				res  = {operand_a[7], operand_a[7:1]};
				fl.c = operand_a[0];
			end
			OP_SRL: begin
				res  = {1'b0, operand_a[7:1]};
				fl.c = operand_a[0];
			end
			OP_SWAP: begin
				res = {operand_a[3:0], operand_a[7:4]};
			end
			OP_CCF: begin
				fl.c = ~flags_cur.c;
			end
			OP_INC: begin
				res  = operand_a + data_t'(1);
				fl.h = &operand_a[3:0];
				fl.c = flags_cur.c;
			end
			default: begin
				// unused codes leave everything alone
				known = 1'b0;
			end
		endcase
		// zero flag from the result, except ccf keeps it
		fl.z = (op == OP_CCF) ? flags_cur.z : (res == '0);
	end

	assign result    = res;
	assign flags_nxt = known ? fl : flags_cur;

endmodule

`default_nettype wire

@@ design/cpu_alu_8bit_with_flags_core.sv @@
`default_nettype none
// 2 stages (input register, result register); one word per cycle unless out_ready stalls
// the flag feedback closes within the execute stage
// the stored flags are written when a word moves from the input to the result register
// reset (arst_n low, asynchronous): both stages empty, all four flags cleared
// output flags are wired straight from the stored flags, so both change at the same edge
// ----------------------------------------------------------------------------
// cpu_alu_8bit_with_flags_core
// 8-bit alu with z/n/h/c flag register, input register and result register
// ----------------------------------------------------------------------------
module cpu_alu_8bit_with_flags_core import calu_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [OpWidth-1:0] op,
	input  wire data_t              operand_a,
	input  wire data_t              operand_b,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output data_t                   result,
	output logic                    zero_flag,
	output logic                    subtract_flag,
	output logic                    half_flag,
	output logic                    carry_flag
);

	// stage 1: captured input word
	logic               valid_s1;
	logic [OpWidth-1:0] op_s1;
	data_t              a_s1;
	data_t              b_s1;

	// stage 2: result word
	logic               valid_s2;
	data_t              result_s2;

	// architectural flag register
	flags_t flags_q;

	// execute outputs
	data_t  exec_result;
	flags_t exec_flags;

	logic adv_s1;
	logic take_in;

	// stage 1 moves on when the result register is empty or being drained
	assign adv_s1  = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | adv_s1;
	assign take_in  = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1 <= op;
			a_s1  <= operand_a;
			b_s1  <= operand_b;
		end
	end

	calu_exec u_exec (
		.op        (op_s1),
		.operand_a (a_s1),
		.operand_b (b_s1),
		.flags_cur (flags_q),
		.result    (exec_result),
		.flags_nxt (exec_flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			flags_q  <= FlagsReset;
		end else begin
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				flags_q  <= exec_flags;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= exec_result;
		end
	end

	assign out_valid     = valid_s2;
	assign result        = result_s2;
	assign zero_flag     = flags_q.z;
	assign subtract_flag = flags_q.n;
	assign half_flag     = flags_q.h;
	assign carry_flag    = flags_q.c;

	// flags change only when a word enters the result register
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(flags_q))
		else $error("flag register changed without a word moving");

	// a free result register never stalls the input
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1 || !valid_s2) |-> in_ready)
		else $error("input stalled with room in the pipeline");

	// sub and sbc always leave n set
	a_n_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (op_s1 == OP_SUB || op_s1 == OP_SBC)) |=> subtract_flag)
		else $error("subtract flag not set after sub or sbc");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives op/operand words into the 8-bit alu with z/n/h/c flags through a
// valid/ready channel, predicts each result word and the running flag
// register, and compares every returned word field by field in order
// ----------------------------------------------------------------------------
module testbench;
	import calu_pkg::*;

	// op codes 12 to 15 are not defined and must act as a no-op
	localparam logic [OpWidth-1:0] OpUndefFirst = 4'd12;
	localparam logic [OpWidth-1:0] OpUndefLast  = 4'd15;

	localparam int RandomWords = 650;
	localparam int CycleLimit  = 200000;
	localparam int LongHold    = 80;

	// one returned word: the result byte and the four flags
	typedef struct packed {
		data_t  result;
		flags_t flags;
	} alu_word_t;

	// one row of the directed table; typed rows carry their own expectation
	typedef struct packed {
		logic [OpWidth-1:0] op;
		data_t              a;
		data_t              b;
		logic               typed;
		data_t              r;
		flags_t             f;
	} stim_row_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [OpWidth-1:0] op = '0;
	data_t              operand_a = '0;
	data_t              operand_b = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	data_t              result;
	logic               zero_flag;
	logic               subtract_flag;
	logic               half_flag;
	logic               carry_flag;

	// expectation travelling with the payload, so the scoreboard sees it at acceptance
	logic      stim_typed = 1'b0;
	alu_word_t stim_typed_word = '0;

	flags_t    flag_reg = FlagsReset;
	alu_word_t alu_words_due[$];
	int        words_accepted = 0;
	int        words_checked = 0;
	int        mismatch_count = 0;
	int        cycle_count = 0;
	int        op_seen[16];
	bit        long_hold_req = 1'b0;

	// directed words, starting from the reset flags: extremes, every op,
	// carry-in from the previous word, ccf keeping z, undefined codes
	stim_row_t directed_rows [0:22] = '{
		'{OP_ADD,  8'h00, 8'h00, 1'b1, 8'h00, 4'b1000},
		'{OP_ADC,  8'hFF, 8'h01, 1'b1, 8'h00, 4'b1011},
		'{OP_ADC,  8'h00, 8'h00, 1'b0, 8'h00, 4'b0000},
		'{OP_SUB,  8'h00, 8'h01, 1'b1, 8'hFF, 4'b0111},
		'{OP_SBC,  8'h10, 8'h0F, 1'b0, 8'h00, 4'b0000},
		'{OP_SBC,  8'hFF, 8'hFF, 1'b1, 8'h00, 4'b1100},
		'{OP_CCF,  8'h5A, 8'h00, 1'b0, 8'h00, 4'b0000},
		'{OP_CCF,  8'hA5, 8'hFF, 1'b0, 8'h00, 4'b0000},
		'{OP_RLC,  8'h80, 8'h00, 1'b0, 8'h00, 4'b0000},
		'{OP_RRC,  8'h01, 8'h00, 1'b0, 8'h00, 4'b0000},
		'{OP_SLA,  8'h80, 8'h00, 1'b0, 8'h00, 4'b0000},
		'{OP_SRA,  8'h81, 8'h00, 1'b0, 8'h00, 4'b0000},
		'{OP_SRL,  8'h81, 8'h00, 1'b0, 8'h00, 4'b0000},
		'{OP_SWAP, 8'hF0, 8'h00, 1'b0, 8'h00, 4'b0000},
		'{OP_INC,  8'hFF, 8'h00, 1'b1, 8'h00, 4'b1010},
		'{OP_SRL,  8'h01, 8'h00, 1'b0, 8'h00, 4'b0000},
		'{OP_INC,  8'h7F, 8'h00, 1'b0, 8'h00, 4'b0000},
		'{OpUndefFirst, 8'h33, 8'hCC, 1'b1, 8'h33, 4'b0011},
		'{OpUndefLast,  8'hFF, 8'hFF, 1'b1, 8'hFF, 4'b0011},
		'{OP_ADD,  8'hFF, 8'hFF, 1'b1, 8'hFE, 4'b0011},
		'{OP_SUB,  8'hFF, 8'h00, 1'b1, 8'hFF, 4'b0100},
		'{OP_RLC,  8'h00, 8'h00, 1'b0, 8'h00, 4'b0000},
		'{OP_SWAP, 8'h00, 8'hFF, 1'b0, 8'h00, 4'b0000}
	};

	cpu_alu_8bit_with_flags_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.operand_a     (operand_a),
		.operand_b     (operand_b),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result        (result),
		.zero_flag     (zero_flag),
		.subtract_flag (subtract_flag),
		.half_flag     (half_flag),
		.carry_flag    (carry_flag)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// works out the result word for one accepted input word and updates
	// the shadow flag register the same way the block does
	function automatic alu_word_t calc_alu_word(input logic [OpWidth-1:0] w_op,
			input data_t a, input data_t b);
		logic     cin;
		logic     ci;
		logic [8:0] sum9;
		logic [4:0] nib5;
		data_t    r;
		flags_t   nf;
		cin = flag_reg.c;
		ci  = 1'b0;
		r   = a;
		nf  = '0;
		case (w_op)
			OP_ADD, OP_ADC: begin
				ci   = (w_op == OP_ADC) ? cin : 1'b0;
				sum9 = {1'b0, a} + {1'b0, b} + ci;
				nib5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + ci;
				nf.h = nib5[4];
				nf.c = sum9[8];
				r    = sum9[7:0];
			end
			OP_SUB, OP_SBC: begin
				ci   = (w_op == OP_SBC) ? cin : 1'b0;
				nf.n = 1'b1;
				// borrows from bit 4 and bit 8, borrow-in included
				nf.h = ({1'b0, a[3:0]} < ({1'b0, b[3:0]} + ci));
				nf.c = ({1'b0, a} < ({1'b0, b} + ci));
				r    = a - b - ci;
			end
			OP_RLC: begin
				nf.c = a[7];
				r    = {a[6:0], a[7]};
			end
			OP_RRC: begin
				nf.c = a[0];
				r    = {a[0], a[7:1]};
			end
			OP_SLA: begin
				nf.c = a[7];
				r    = {a[6:0], 1'b0};
			end
			OP_SRA: begin
				nf.c = a[0];
				r    = {a[7], a[7:1]};
			end
			OP_SRL: begin
				nf.c = a[0];
				r    = {1'b0, a[7:1]};
			end
			OP_SWAP: r = {a[3:0], a[7:4]};
			OP_CCF: begin
				nf.c = ~cin;
				r    = a;
			end
			OP_INC: begin
				nf.h = (a[3:0] == 4'hF);
				nf.c = cin;
				r    = a + 8'd1;
			end
			default: r = a;
		endcase
		// undefined codes leave the flags alone
		if (w_op <= OP_INC) begin
			nf.z = (w_op == OP_CCF) ? flag_reg.z : (r == 8'h00);
			flag_reg = nf;
		end
		return '{result: r, flags: flag_reg};
	endfunction

	// gap before the next word: mode 0 back to back, 1 occasional, 2 always random
	function automatic int draw_gap(input int mode);
		case (mode)
			0: return 0;
			1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
			default: return $urandom_range(0, 14);
		endcase
	endfunction

	// operand with a bias toward the nibble and byte boundaries
	function automatic data_t pick_operand();
		data_t corners[8];
		corners = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h7F, 8'h80, 8'h01, 8'h10};
		if ($urandom_range(0, 4) == 0)
			return corners[$urandom_range(0, 7)];
		return data_t'($urandom_range(0, 255));
	endfunction

	task automatic check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	// offer one word after a gap and hold it until the block takes it
	task automatic offer_word(input logic [OpWidth-1:0] w_op, input data_t w_a,
			input data_t w_b, input logic w_typed, input alu_word_t w_exp, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		op              <= w_op;
		operand_a       <= w_a;
		operand_b       <= w_b;
		stim_typed      <= w_typed;
		stim_typed_word <= w_exp;
		do @(posedge clk); while (!in_ready);
		words_accepted++;
	endtask

	// stop offering and wait until every accepted word has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_checked < words_accepted) @(posedge clk);
	endtask

	// scoreboard: output side first, then the input side, in one process so
	// the order within a time step does not matter
	always @(posedge clk) begin : scoreboard
		alu_word_t due;
		alu_word_t predicted;
		if (out_valid && out_ready) begin
			if (alu_words_due.size() == 0) begin
				mismatch_count++;
				$display("%0t: result word %02h with nothing expected, expected none, actual %02h",
					$time, result, result);
			end else begin
				due = alu_words_due.pop_front();
				check_field("result", due.result, result);
				check_field("zero_flag", due.flags.z, zero_flag);
				check_field("subtract_flag", due.flags.n, subtract_flag);
				check_field("half_flag", due.flags.h, half_flag);
				check_field("carry_flag", due.flags.c, carry_flag);
			end
			words_checked++;
		end
		if (in_valid && in_ready) begin
			// the predictor runs on every word so the shadow flags stay in step
			predicted = calc_alu_word(op, operand_a, operand_b);
			alu_words_due.push_back(stim_typed ? stim_typed_word : predicted);
			op_seen[op]++;
		end
	end

	// receiver: random stalls per word, with one long hold on request
	initial begin : result_sink
		int stall;
		int mode;
		int taken;
		mode  = 0;
		taken = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (taken % 40 == 0)
				mode = $urandom_range(0, 2);
			if (long_hold_req) begin
				// hold off long enough for both stages to fill and in_ready to drop
				stall = LongHold;
				long_hold_req = 1'b0;
			end else begin
				stall = draw_gap(mode);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("%0t: run limit of %0d cycles reached", $time, CycleLimit);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// sender and end of run
	initial begin : stimulus
		int mode;
		int gap;
		int undef_words;
		logic [OpWidth-1:0] r_op;
		for (int i = 0; i < 16; i++)
			op_seen[i] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			offer_word(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
				directed_rows[i].typed, '{result: directed_rows[i].r, flags: directed_rows[i].f},
				draw_gap(2));
		end
		wait_drained();

		// random words, mostly defined ops with a share of undefined codes
		mode = 0;
		for (int k = 0; k < RandomWords; k++) begin
			if (k % 40 == 0)
				mode = $urandom_range(0, 2);
			if (k == 200)
				long_hold_req = 1'b1;
			if (k == 400)
				wait_drained();
			// back to back while the receiver holds off, so the input stalls
			gap = (k >= 200 && k < 260) ? 0 : draw_gap(mode);
			if ($urandom_range(0, 99) < 90)
				r_op = OpWidth'($urandom_range(OP_ADD, OP_INC));
			else
				r_op = OpWidth'($urandom_range(OpUndefFirst, OpUndefLast));
			offer_word(r_op, pick_operand(), pick_operand(), 1'b0, '0, gap);
		end
		wait_drained();
		// keep clocking so any stray word still shows up
		repeat (8) @(posedge clk);

		if (alu_words_due.size() != 0) begin
			mismatch_count += alu_words_due.size();
			$display("%0t: %0d expected words never returned, expected 0, actual %0d",
				$time, alu_words_due.size(), alu_words_due.size());
		end
		undef_words = op_seen[12] + op_seen[13] + op_seen[14] + op_seen[15];
		$display("covered: %0d words in, %0d results checked, %0d with undefined op codes",
			words_accepted, words_checked, undef_words);
		$display("covered: random idling on both ends, one long output hold, two drain pauses");
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ sim.f @@
design/calu_pkg.sv
design/calu_exec.sv
design/cpu_alu_8bit_with_flags_core.sv
sim/testbench.sv
